### src/rrac_pkg.sv
`timescale 1ns / 1ps
// Shared types, field widths and request codes for the range array block.
package rrac_pkg;

    localparam int POS_W  = 13;
    localparam int VAL_W  = 31;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 13;

    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COUNT   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ASSIGN  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_REVERSE = 2'd3;

    localparam logic [POS_W-1:0] LEN_RESET = 13'd4096;
    localparam logic [POS_W-1:0] POS_MAX   = 13'd8191;

    localparam logic [1:0] WSRC_VALUE = 2'd0;
    localparam logic [1:0] WSRC_HOLD  = 2'd1;
    localparam logic [1:0] WSRC_RDATA = 2'd2;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       rd_sel_j;
        logic       wr_en;
        logic       wr_sel_j;
        logic [1:0] wr_src;
        logic       inc_i;
        logic       dec_j;
        logic       hold_cap;
        logic       cnt_rd;
        logic       out_push;
    } rrac_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              empty;
        logic              load_ok;
        logic              i_lt_j;
        logic              i_eq_j;
        logic              out_free;
    } rrac_stat_t;

endpackage

### src/range_reverse_assign_count_array.sv
`timescale 1ns / 1ps
// Top level: range array with load, count, assign and reverse requests and an APB register.
//
//  channel   ports                                   direction
//  s_        s_valid s_ready s_kind s_left s_right    request in
//            s_value
//  m_        m_valid m_ready m_count                  count result out
//  apb       psel penable pwrite paddr pwdata         active_length register
//            prdata pready
//
// A request is taken only when the block is idle; all elements sit in one RAM with one
// read and one write port, and count, assign and reverse walk the clipped range in that RAM.
// An empty range skips the walk; a count over it still returns a result of zero.
// A count result waits in the output register, so only a further count stalls on m_ready.
// Reset is synchronous and clears control state only; elements are undefined until loaded.
module range_reverse_assign_count_array #(
    parameter int DEPTH = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rrac_pkg::KIND_W-1:0] s_kind,
    input  logic [rrac_pkg::POS_W-1:0]  s_left,
    input  logic [rrac_pkg::POS_W-1:0]  s_right,
    input  logic [rrac_pkg::VAL_W-1:0]  s_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rrac_pkg::CNT_W-1:0]  m_count,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import rrac_pkg::*;

    rrac_cmd_t        cmd;
    rrac_stat_t       stat;
    logic [POS_W-1:0] active_length_reg, active_length_next;

    assign pready = 1'b1;

    always_comb begin
        active_length_next = active_length_reg;
        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            active_length_next = pwdata[POS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_length_reg <= LEN_RESET;
        end else begin
            active_length_reg <= active_length_next;
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32 - POS_W){1'b0}}, active_length_reg} : '0;

    rrac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rrac_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_kind        (s_kind),
        .s_left        (s_left),
        .s_right       (s_right),
        .s_value       (s_value),
        .active_length (active_length_reg),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_count       (m_count)
    );

endmodule

### src/rrac_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module rrac_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/rrac_dp.sv
`timescale 1ns / 1ps
// Datapath: request registers, range pointers, element RAM, counter and result register.
module rrac_dp #(
    parameter int DEPTH = 4096
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rrac_pkg::rrac_cmd_t         cmd,
    output rrac_pkg::rrac_stat_t        stat,
    input  logic [rrac_pkg::KIND_W-1:0] s_kind,
    input  logic [rrac_pkg::POS_W-1:0]  s_left,
    input  logic [rrac_pkg::POS_W-1:0]  s_right,
    input  logic [rrac_pkg::VAL_W-1:0]  s_value,
    input  logic [rrac_pkg::POS_W-1:0]  active_length,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [rrac_pkg::CNT_W-1:0]  m_count
);
    import rrac_pkg::*;

    localparam int AW     = $clog2(DEPTH);
    localparam int IW     = (POS_W > AW) ? POS_W : AW;
    localparam int LenCap = (DEPTH > 8191) ? 8191 : DEPTH;
    localparam logic [POS_W-1:0] LEN_CAP = POS_W'(LenCap);

    logic [POS_W-1:0]  len;
    logic [POS_W-1:0]  left_c;
    logic [POS_W-1:0]  right_c;
    logic              empty_in;
    logic              load_ok_in;

    logic [KIND_W-1:0] kind_reg,    kind_next;
    logic [VAL_W-1:0]  value_reg,   value_next;
    logic [IW-1:0]     i_reg,       i_next;
    logic [IW-1:0]     j_reg,       j_next;
    logic              empty_reg,   empty_next;
    logic              load_ok_reg, load_ok_next;
    logic [VAL_W-1:0]  hold_reg,    hold_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic              pend_reg,    pend_next;
    logic              m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]  m_count_reg, m_count_next;

    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic [VAL_W-1:0]  rd_data;

    assign len        = (active_length > LEN_CAP) ? LEN_CAP : active_length;
    assign left_c     = (s_left == '0) ? POS_W'(1) : s_left;
    assign right_c    = (s_right > len) ? len : s_right;
    assign empty_in   = left_c > right_c;
    assign load_ok_in = (s_left != '0) && (s_left <= len);

    assign rd_addr = cmd.rd_sel_j ? j_reg[AW-1:0] : i_reg[AW-1:0];
    assign wr_addr = cmd.wr_sel_j ? j_reg[AW-1:0] : i_reg[AW-1:0];

    always_comb begin
        case (cmd.wr_src)
            WSRC_VALUE: wr_data = value_reg;
            WSRC_HOLD:  wr_data = hold_reg;
            default:    wr_data = rd_data;
        endcase
    end

    rrac_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        kind_next    = kind_reg;
        value_next   = value_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        empty_next   = empty_reg;
        load_ok_next = load_ok_reg;
        hold_next    = cmd.hold_cap ? rd_data : hold_reg;
        count_next   = count_reg;
        pend_next    = cmd.cnt_rd;
        m_valid_next = m_valid_reg;
        m_count_next = m_count_reg;
        if (cmd.capture) begin
            kind_next    = s_kind;
            value_next   = s_value;
            i_next       = IW'(left_c - POS_W'(1));
            j_next       = IW'(right_c - POS_W'(1));
            empty_next   = empty_in;
            load_ok_next = load_ok_in;
            count_next   = '0;
        end else begin
            if (cmd.inc_i) begin
                i_next = i_reg + IW'(1);
            end
            if (cmd.dec_j) begin
                j_next = j_reg - IW'(1);
            end
            if (pend_reg && (rd_data >= value_reg) && (count_reg != '1)) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.out_push) begin
            m_valid_next = 1'b1;
            m_count_next = count_reg;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
        kind_reg    <= kind_next;
        value_reg   <= value_next;
        i_reg       <= i_next;
        j_reg       <= j_next;
        empty_reg   <= empty_next;
        load_ok_reg <= load_ok_next;
        hold_reg    <= hold_next;
        count_reg   <= count_next;
        m_count_reg <= m_count_next;
    end

    assign stat.kind     = kind_reg;
    assign stat.empty    = empty_reg;
    assign stat.load_ok  = load_ok_reg;
    assign stat.i_lt_j   = i_reg < j_reg;
    assign stat.i_eq_j   = i_reg == j_reg;
    assign stat.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

endmodule

### src/rrac_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences load, count, assign and reverse walks over the element RAM.
module rrac_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rrac_pkg::rrac_stat_t stat,
    output rrac_pkg::rrac_cmd_t  cmd
);
    import rrac_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_DECODE  = 4'd1;
    localparam logic [3:0] ST_CNT_RD  = 4'd2;
    localparam logic [3:0] ST_CNT_END = 4'd3;
    localparam logic [3:0] ST_RESULT  = 4'd4;
    localparam logic [3:0] ST_ASN_WR  = 4'd5;
    localparam logic [3:0] ST_REV_RDI = 4'd6;
    localparam logic [3:0] ST_REV_RDJ = 4'd7;
    localparam logic [3:0] ST_REV_WRJ = 4'd8;
    localparam logic [3:0] ST_REV_WRI = 4'd9;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (stat.kind)
                    KIND_LOAD: begin
                        cmd.wr_en  = stat.load_ok;
                        cmd.wr_src = WSRC_VALUE;
                        state_next = ST_IDLE;
                    end
                    KIND_COUNT:  state_next = stat.empty ? ST_RESULT : ST_CNT_RD;
                    KIND_ASSIGN: state_next = stat.empty ? ST_IDLE : ST_ASN_WR;
                    KIND_REVERSE: state_next = stat.empty ? ST_IDLE : ST_REV_RDI;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_CNT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.cnt_rd = 1'b1;
                cmd.inc_i  = 1'b1;
                if (stat.i_eq_j) begin
                    state_next = ST_CNT_END;
                end
            end
            ST_CNT_END: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (stat.out_free) begin
                    cmd.out_push = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_ASN_WR: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_VALUE;
                cmd.inc_i  = 1'b1;
                if (stat.i_eq_j) begin
                    state_next = ST_IDLE;
                end
            end
            ST_REV_RDI: begin
                if (stat.i_lt_j) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_REV_RDJ;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_REV_RDJ: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel_j = 1'b1;
                cmd.hold_cap = 1'b1;
                state_next   = ST_REV_WRJ;
            end
            ST_REV_WRJ: begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel_j = 1'b1;
                cmd.wr_src   = WSRC_HOLD;
                state_next   = ST_REV_WRI;
            end
            ST_REV_WRI: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_src = WSRC_RDATA;
                cmd.inc_i  = 1'b1;
                cmd.dec_j  = 1'b1;
                state_next = ST_REV_RDI;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/rrac_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the range array block, bound to the top level.
module rrac_chk (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic [rrac_pkg::CNT_W-1:0] m_count,
    input logic                       pready
);

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_count)))
        else $error("result dropped or changed while stalled");

    a_busy_after_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while previous request still in work");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared without a request in work");

    a_pready_high: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("register port stalled");

endmodule

bind range_reverse_assign_count_array rrac_chk u_chk (.*);

### tb/range_reverse_assign_count_array_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the range array block: load, count, assign and reverse requests.
module range_reverse_assign_count_array_tb;

    import rrac_pkg::*;

    localparam int DEPTH          = 4096;
    localparam int DRAIN_CYCLES   = 4 * DEPTH + 64;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam logic [2:0] ADDR_ACTIVE_LENGTH = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;
    localparam logic [VAL_W-1:0] VALUE_TOP    = {VAL_W{1'b1}};

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  left;
        logic [POS_W-1:0]  right;
        logic [VAL_W-1:0]  value;
    } range_req_t;

    logic              aclk    = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [KIND_W-1:0] s_kind  = KIND_LOAD;
    logic [POS_W-1:0]  s_left  = '0;
    logic [POS_W-1:0]  s_right = '0;
    logic [VAL_W-1:0]  s_value = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [CNT_W-1:0]  m_count;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [2:0]        paddr   = '0;
    logic [31:0]       pwdata  = '0;
    logic [31:0]       prdata;
    logic              pready;

    range_req_t        pending_requests[$];
    logic [CNT_W-1:0]  due_counts[$];
    logic [VAL_W-1:0]  element_model[DEPTH];
    logic [POS_W-1:0]  active_len = LEN_RESET;
    logic              req_taken = 1'b0;
    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                idle_cycles = 0;
    int                errors = 0;

    range_reverse_assign_count_array #(
        .DEPTH(DEPTH)
    ) dut (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind (s_kind),
        .s_left (s_left),
        .s_right(s_right),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_count(m_count),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic apply_request(input range_req_t rq);
        int unsigned usable;
        int unsigned lo;
        int unsigned hi;
        int unsigned i;
        int unsigned j;
        int unsigned tally;
        logic [VAL_W-1:0] swap;
        usable = (active_len > DEPTH) ? DEPTH : active_len;
        if (rq.kind == KIND_LOAD) begin
            if (rq.left >= 1 && rq.left <= usable) begin
                element_model[rq.left - 1] = rq.value;
            end
            return;
        end
        lo = (rq.left < 1) ? 1 : rq.left;
        hi = (rq.right > usable) ? usable : rq.right;
        if (rq.kind == KIND_COUNT) begin
            tally = 0;
            if (lo <= hi) begin
                for (i = lo - 1; i < hi; i++) begin
                    if (element_model[i] >= rq.value && tally < POS_MAX) begin
                        tally++;
                    end
                end
            end
            due_counts.push_back(tally[CNT_W-1:0]);
            return;
        end
        if (lo > hi) begin
            return;
        end
        if (rq.kind == KIND_ASSIGN) begin
            for (i = lo - 1; i < hi; i++) begin
                element_model[i] = rq.value;
            end
        end else begin
            i = lo - 1;
            j = hi - 1;
            while (i < j) begin
                swap = element_model[i];
                element_model[i] = element_model[j];
                element_model[j] = swap;
                i++;
                j--;
            end
        end
    endtask

    // Check results, predict accepted requests, watch for a hang.
    always @(posedge aclk) begin : monitor
        logic [CNT_W-1:0] want;
        range_req_t rq;
        if (m_valid && m_ready) begin
            if (due_counts.size() == 0) begin
                $display("%0t: unexpected count result %0d", $time, m_count);
                errors = errors + 1;
            end else begin
                want = due_counts[0];
                due_counts.delete(0);
                if (m_count !== want) begin
                    $display("%0t: count mismatch: expected %0d, actual %0d",
                             $time, want, m_count);
                    errors = errors + 1;
                end
            end
        end
        if (s_valid && s_ready) begin
            rq.kind  = s_kind;
            rq.left  = s_left;
            rq.right = s_right;
            rq.value = s_value;
            apply_request(rq);
        end
        req_taken <= s_valid && s_ready;
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(negedge aclk) begin : drive_requests
        logic holding;
        holding = s_valid && !req_taken;
        if (s_valid && req_taken) begin
            pending_requests.delete(0);
        end
        if (!holding) begin
            if (pending_requests.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
                s_valid <= 1'b1;
                s_kind  <= pending_requests[0].kind;
                s_left  <= pending_requests[0].left;
                s_right <= pending_requests[0].right;
                s_value <= pending_requests[0].value;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data,
                              output logic [31:0] rd);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_length_readback();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_ACTIVE_LENGTH, 32'd0, rd);
        if (rd !== {19'd0, active_len}) begin
            $display("%0t: active_length readback mismatch: expected %0d, actual %0d",
                     $time, active_len, rd);
            errors = errors + 1;
        end
    endtask

    task automatic write_active_length(input logic [31:0] word);
        logic [31:0] rd;
        apb_access(1'b1, ADDR_ACTIVE_LENGTH, word, rd);
        active_len = word[POS_W-1:0];
        check_length_readback();
    endtask

    // Hold until every request is taken and every count is back, then let the block drain.
    task automatic settle_block();
        while (pending_requests.size() != 0 || s_valid || due_counts.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic queue_request(input logic [KIND_W-1:0] kind, input int unsigned left,
                                 input int unsigned right, input logic [VAL_W-1:0] value);
        range_req_t rq;
        rq.kind  = kind;
        rq.left  = left[POS_W-1:0];
        rq.right = right[POS_W-1:0];
        rq.value = value;
        pending_requests.push_back(rq);
    endtask

    function automatic range_req_t random_request(input int unsigned usable);
        range_req_t rq;
        int unsigned span;
        int unsigned lo;
        int unsigned hi;
        rq.kind = KIND_W'($urandom_range(3));
        if (usable == 0 || $urandom_range(99) < 12) begin
            rq.left  = POS_W'($urandom_range(8191));
            rq.right = POS_W'($urandom_range(8191));
        end else begin
            span = (usable > 64 && $urandom_range(99) >= 4) ? 64 : usable;
            lo = $urandom_range(usable, 1);
            hi = lo + $urandom_range(span - 1);
            if (hi > usable) begin
                hi = usable;
            end
            rq.left  = lo[POS_W-1:0];
            rq.right = (rq.kind == KIND_LOAD) ? POS_W'($urandom_range(8191)) : hi[POS_W-1:0];
        end
        case ($urandom_range(3))
            0: rq.value = VAL_W'($urandom_range(7));
            1: rq.value = VAL_W'($urandom);
            2: rq.value = ($urandom_range(1) != 0) ? VALUE_TOP : '0;
            default: rq.value = VAL_W'($urandom_range(3));
        endcase
        return rq;
    endfunction

    task automatic run_phase(input logic [31:0] len_word, input int items,
                             input int send_idle, input int recv_stall);
        int unsigned usable;
        settle_block();
        write_active_length(len_word);
        sender_idle_pct    = send_idle;
        receiver_stall_pct = recv_stall;
        usable = (active_len > DEPTH) ? DEPTH : active_len;
        repeat (items) pending_requests.push_back(random_request(usable));
    endtask

    initial begin : stimulus
        logic [31:0] rd;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        check_length_readback();

        queue_request(KIND_ASSIGN, 1, 4096, 31'd5);
        queue_request(KIND_COUNT, 1, 4096, 31'd0);
        queue_request(KIND_COUNT, 1, 4096, 31'd6);
        queue_request(KIND_LOAD, 1, 8191, VALUE_TOP);
        queue_request(KIND_LOAD, 4096, 0, 31'd0);
        queue_request(KIND_LOAD, 0, 1, 31'd9);
        queue_request(KIND_LOAD, 4097, 1, 31'd9);
        queue_request(KIND_LOAD, 8191, 8191, 31'd9);
        queue_request(KIND_COUNT, 1, 1, VALUE_TOP);
        queue_request(KIND_COUNT, 4096, 4096, 31'd0);
        queue_request(KIND_COUNT, 0, 8191, 31'd5);
        queue_request(KIND_COUNT, 10, 3, 31'd0);
        queue_request(KIND_ASSIGN, 9, 2, 31'd1);
        queue_request(KIND_REVERSE, 7, 3, 31'd0);
        queue_request(KIND_REVERSE, 1, 4096, 31'd0);
        queue_request(KIND_COUNT, 4096, 8191, VALUE_TOP);
        queue_request(KIND_LOAD, 2, 0, 31'd3);
        queue_request(KIND_LOAD, 3, 0, 31'd8);
        queue_request(KIND_REVERSE, 2, 3, 31'd0);
        queue_request(KIND_REVERSE, 1, 3, 31'd0);
        queue_request(KIND_COUNT, 1, 3, 31'd3);
        queue_request(KIND_ASSIGN, 4000, 8191, 31'h4000_0000);
        queue_request(KIND_COUNT, 3990, 4096, 31'h4000_0000);
        queue_request(KIND_REVERSE, 5, 5, 31'd0);
        queue_request(KIND_COUNT, 0, 0, 31'd0);

        run_phase(32'd1, 20, 0, 0);
        run_phase(32'd37, 30, 45, 0);
        run_phase(32'd4096, 25, 0, 45);
        run_phase(32'd2, 20, 26, 26);

        settle_block();
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0155, rd);
        check_length_readback();
        run_phase(32'hA5A5_0000, 5, 0, 0);
        run_phase(32'd8191, 10, 26, 26);
        run_phase(32'd300, 15, 45, 45);

        settle_block();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
